@@ rtl/seq_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// seq_pkg
// Shared types and constants for the sorted event queue.
// ---------------------------------------------------------------------------
package seq_pkg;

  localparam int DEPTH_DEFAULT   = 16;
  localparam int ID_BITS_DEFAULT = 8;

  localparam int EVENT_ID_W = 8;
  localparam int SEC_W      = 32;
  localparam int USEC_W     = 20;
  localparam int COUNT_W    = 5;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    op_t                   operation;
    logic [EVENT_ID_W-1:0] event_id;
    logic [SEC_W-1:0]      due_seconds;
    logic [USEC_W-1:0]     due_micros;
  } seq_cmd_t;

  typedef struct packed {
    status_t               status;
    logic                  head_valid;
    logic [EVENT_ID_W-1:0] head_id;
    logic [SEC_W-1:0]      head_seconds;
    logic [USEC_W-1:0]     head_micros;
    logic [COUNT_W-1:0]    queued_count;
  } seq_result_t;

endpackage
`default_nettype wire

@@ rtl/seq_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// seq_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module seq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/sorted_event_queue.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sorted_event_queue
// Time-ordered event queue kept in one slot RAM, walked by a small sequencer.
// ---------------------------------------------------------------------------
// Each item is worked through the single read and write port of the slot
// RAM: a scan over every held slot, then a shift of the slots behind the
// insert or remove point.
// Throughput: one item at a time; busy is high from accept until the strobe.
// The result is shown for one cycle with done and cannot be stalled.
// Reset empties the queue (count zero); slot contents are left as they are.
module sorted_event_queue
  import seq_pkg::*;
#(
  parameter int DEPTH   = DEPTH_DEFAULT,
  parameter int ID_BITS = ID_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire seq_cmd_t    cmd,
  output logic             busy,
  output logic             done,
  output seq_result_t      result
);

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ENTRY_W = ID_BITS + SEC_W + USEC_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_WRNEW,
    S_HEAD,
    S_RESP
  } state_t;

  state_t              state;
  op_t                 op_r;
  logic [ID_BITS-1:0]  id_r;
  logic [SEC_W-1:0]    sec_r;
  logic [USEC_W-1:0]   usec_r;
  status_t             status_r;
  logic [CNT_W-1:0]    fill;
  logic [CNT_W-1:0]    scan_idx;
  logic [CNT_W-1:0]    cmp_idx;
  logic                cmp_valid;
  logic                found;
  logic                pos_set;
  logic [CNT_W-1:0]    pos;
  logic [CNT_W-1:0]    wr_tgt;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [CNT_W-1:0]    rd_ptr;
  logic [ENTRY_W-1:0]  ram_rdata;

  logic [ID_BITS-1:0]  e_id;
  logic [SEC_W-1:0]    e_sec;
  logic [USEC_W-1:0]   e_usec;
  logic                new_before;

  seq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_ptr[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign e_id   = ram_rdata[ENTRY_W-1 -: ID_BITS];
  assign e_sec  = ram_rdata[SEC_W+USEC_W-1 -: SEC_W];
  assign e_usec = ram_rdata[USEC_W-1:0];

  // Strictly earlier: the new event goes after every slot of equal time.
  assign new_before = {sec_r, usec_r} < {e_sec, e_usec};

  always_comb begin
    rd_ptr    = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;
    unique case (state)
      S_SCAN: begin
        rd_ptr = scan_idx;
      end
      S_DECIDE: begin
        if (op_r == OP_INSERT) begin
          rd_ptr = CNT_W'(fill - 1'b1);
        end else begin
          rd_ptr = CNT_W'(pos + 1'b1);
        end
      end
      S_SHIFT_UP: begin
        rd_ptr    = CNT_W'(wr_tgt - 2'd2);
        ram_we    = 1'b1;
        ram_waddr = wr_tgt[IDX_W-1:0];
      end
      S_SHIFT_DN: begin
        rd_ptr    = CNT_W'(wr_tgt + 2'd2);
        ram_we    = 1'b1;
        ram_waddr = wr_tgt[IDX_W-1:0];
      end
      S_WRNEW: begin
        ram_we    = 1'b1;
        ram_waddr = pos[IDX_W-1:0];
        ram_wdata = {id_r, sec_r, usec_r};
      end
      default: begin
        rd_ptr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
      fill  <= '0;
    end else begin
      done <= (state == S_RESP);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            busy      <= 1'b1;
            op_r      <= cmd.operation;
            id_r      <= ID_BITS'(cmd.event_id);
            sec_r     <= cmd.due_seconds;
            usec_r    <= cmd.due_micros;
            status_r  <= ST_DONE;
            scan_idx  <= '0;
            cmp_valid <= 1'b0;
            found     <= 1'b0;
            pos_set   <= 1'b0;
            pos       <= fill;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_idx < fill) begin
            cmp_valid <= 1'b1;
            cmp_idx   <= scan_idx;
            scan_idx  <= CNT_W'(scan_idx + 1'b1);
          end else begin
            cmp_valid <= 1'b0;
          end
          if (cmp_valid) begin
            if (e_id == id_r) begin
              found <= 1'b1;
              if (op_r == OP_REMOVE) begin
                pos <= cmp_idx;
              end
            end
            if (op_r == OP_INSERT && !pos_set && new_before) begin
              pos     <= cmp_idx;
              pos_set <= 1'b1;
            end
          end
          // The last read has been checked once nothing more is in flight.
          if (!cmp_valid && scan_idx == fill) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (op_r == OP_INSERT) begin
            if (found) begin
              status_r <= ST_DUPLICATE;
              state    <= S_HEAD;
            end else if (fill == CNT_W'(DEPTH)) begin
              status_r <= ST_FULL;
              state    <= S_HEAD;
            end else if (pos < fill) begin
              wr_tgt <= fill;
              state  <= S_SHIFT_UP;
            end else begin
              state <= S_WRNEW;
            end
          end else begin
            if (!found) begin
              status_r <= ST_NOT_FOUND;
              state    <= S_HEAD;
            end else if (CNT_W'(pos + 1'b1) < fill) begin
              wr_tgt <= pos;
              state  <= S_SHIFT_DN;
            end else begin
              fill  <= CNT_W'(fill - 1'b1);
              state <= S_HEAD;
            end
          end
        end
        S_SHIFT_UP: begin
          if (CNT_W'(wr_tgt - 1'b1) == pos) begin
            state <= S_WRNEW;
          end else begin
            wr_tgt <= CNT_W'(wr_tgt - 1'b1);
          end
        end
        S_SHIFT_DN: begin
          if (CNT_W'(wr_tgt + 2'd2) == fill) begin
            fill  <= CNT_W'(fill - 1'b1);
            state <= S_HEAD;
          end else begin
            wr_tgt <= CNT_W'(wr_tgt + 1'b1);
          end
        end
        S_WRNEW: begin
          fill  <= CNT_W'(fill + 1'b1);
          state <= S_HEAD;
        end
        S_HEAD: begin
          state <= S_RESP;
        end
        S_RESP: begin
          busy                <= 1'b0;
          result.status       <= status_r;
          result.queued_count <= COUNT_W'(fill);
          if (fill != '0) begin
            result.head_valid   <= 1'b1;
            result.head_id      <= EVENT_ID_W'(e_id);
            result.head_seconds <= e_sec;
            result.head_micros  <= e_usec;
          end else begin
            result.head_valid   <= 1'b0;
            result.head_id      <= '0;
            result.head_seconds <= '0;
            result.head_micros  <= '0;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_event_queue. A queue of pending commands is
// driven through the start/busy handshake. Every accepted item is run through
// a time-ordered schedule model kept here, and each done strobe is compared
// field by field with the oldest predicted head.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import seq_pkg::*;

  localparam int QUEUE_DEPTH  = DEPTH_DEFAULT;
  localparam int PHASE_ITEMS  = 450;
  localparam int SETTLE_CYCLES = 60;
  localparam int STALL_LIMIT  = 4000;

  typedef struct {
    seq_cmd_t    cmd;
    int unsigned idle_pct;
    bit          drain;
  } pending_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  seq_cmd_t    cmd = '0;
  logic        busy;
  logic        done;
  seq_result_t result;

  pending_cmd_t pending_cmds[$];
  seq_result_t  expected_heads[$];
  seq_result_t  oldest_head;
  int           in_flight = 0;
  int           mismatches = 0;
  int           quiet_cycles = 0;

  // Schedule model: slot 0 holds the earliest event.
  logic [EVENT_ID_W-1:0] sched_id[QUEUE_DEPTH];
  logic [SEC_W-1:0]      sched_sec[QUEUE_DEPTH];
  logic [USEC_W-1:0]     sched_usec[QUEUE_DEPTH];
  int                    sched_fill = 0;

  // Generator's view of which ids are queued, used to shape the stimulus.
  bit [255:0] plan_present = '0;
  int         plan_count = 0;

  sorted_event_queue dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic seq_result_t schedule_step(seq_cmd_t c);
    seq_result_t r;
    int hit;
    int pos;
    int i;
    r = '0;
    hit = -1;
    for (i = sched_fill - 1; i >= 0; i--) begin
      if (sched_id[i] == c.event_id) hit = i;
    end
    if (c.operation == OP_INSERT) begin
      if (hit >= 0) begin
        r.status = ST_DUPLICATE;
      end else if (sched_fill >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < sched_fill && !(c.due_seconds < sched_sec[pos] ||
               (c.due_seconds == sched_sec[pos] && c.due_micros < sched_usec[pos])))
          pos++;
        for (i = sched_fill; i > pos; i--) begin
          sched_id[i]   = sched_id[i-1];
          sched_sec[i]  = sched_sec[i-1];
          sched_usec[i] = sched_usec[i-1];
        end
        sched_id[pos]   = c.event_id;
        sched_sec[pos]  = c.due_seconds;
        sched_usec[pos] = c.due_micros;
        sched_fill++;
        r.status = ST_DONE;
      end
    end else begin
      if (hit < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        for (i = hit; i + 1 < sched_fill; i++) begin
          sched_id[i]   = sched_id[i+1];
          sched_sec[i]  = sched_sec[i+1];
          sched_usec[i] = sched_usec[i+1];
        end
        sched_fill--;
        r.status = ST_DONE;
      end
    end
    if (sched_fill > 0) begin
      r.head_valid   = 1'b1;
      r.head_id      = sched_id[0];
      r.head_seconds = sched_sec[0];
      r.head_micros  = sched_usec[0];
    end
    r.queued_count = sched_fill[COUNT_W-1:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Queues one command and tracks its effect on the planned id set.
  task automatic add_item(op_t op, logic [7:0] id, logic [31:0] sec, logic [19:0] usec,
                          int unsigned idle_pct, bit drain);
    pending_cmd_t p;
    p.cmd.operation   = op;
    p.cmd.event_id    = id;
    p.cmd.due_seconds = sec;
    p.cmd.due_micros  = usec;
    p.idle_pct        = idle_pct;
    p.drain           = drain;
    pending_cmds.push_back(p);
    if (op == OP_INSERT) begin
      if (!plan_present[id] && plan_count < QUEUE_DEPTH) begin
        plan_present[id] = 1'b1;
        plan_count++;
      end
    end else if (plan_present[id]) begin
      plan_present[id] = 1'b0;
      plan_count--;
    end
  endtask

  function automatic logic [7:0] pick_id(bit want_present);
    logic [7:0] id;
    id = 8'($urandom_range(0, 255));
    while (plan_present[id] != want_present) id = 8'($urandom_range(0, 255));
    return id;
  endfunction

  // Due times cluster on a few values so that ties and near ties are common.
  task automatic pick_due(output logic [31:0] sec, output logic [19:0] usec);
    case ($urandom_range(0, 5))
      0:       sec = $urandom_range(0, 3);
      1:       sec = 32'hFFFF_FFFF - $urandom_range(0, 2);
      5:       sec = $urandom;
      default: sec = 1000 + $urandom_range(0, 7);
    endcase
    case ($urandom_range(0, 4))
      0:       usec = '0;
      1:       usec = 20'd999999;
      2:       usec = 20'($urandom_range(0, 3));
      3:       usec = 20'($urandom_range(0, 20'hFFFFF));
      default: usec = 20'($urandom_range(0, 999999));
    endcase
  endtask

  task automatic add_random_phase(int unsigned idle_pct);
    int          n;
    int unsigned insert_pct;
    int unsigned r;
    logic [31:0] sec;
    logic [19:0] usec;
    insert_pct = 50;
    for (n = 0; n < PHASE_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0:       insert_pct = 25;
          1:       insert_pct = 50;
          2:       insert_pct = 75;
          default: insert_pct = 92;
        endcase
      end
      pick_due(sec, usec);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        add_item(op_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), $urandom,
                 20'($urandom_range(0, 20'hFFFFF)), idle_pct, n == 0);
      end else if (r < 13 && plan_count > 0) begin
        add_item(OP_INSERT, pick_id(1'b1), sec, usec, idle_pct, n == 0);
      end else if (r < 18) begin
        add_item(OP_REMOVE, pick_id(1'b0), sec, usec, idle_pct, n == 0);
      end else if (plan_count == 0 || $urandom_range(0, 99) < insert_pct) begin
        add_item(OP_INSERT, pick_id(1'b0), sec, usec, idle_pct, n == 0);
      end else begin
        add_item(OP_REMOVE, pick_id(1'b1), sec, usec, idle_pct, n == 0);
      end
    end
  endtask

  // Driver: at most one assignment to start per edge, so a held start never
  // drops for a cycle between back-to-back items.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cmd   <= '0;
    end else begin
      if (done) in_flight--;
      if (start && !busy) begin
        expected_heads.push_back(schedule_step(cmd));
        in_flight++;
      end
      if (!start || !busy) begin
        if (pending_cmds.size() != 0 && !(pending_cmds[0].drain && in_flight != 0) &&
            $urandom_range(0, 99) >= pending_cmds[0].idle_pct) begin
          start <= 1'b1;
          cmd   <= pending_cmds[0].cmd;
          void'(pending_cmds.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done strobe is one result item.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_heads.size() == 0) begin
        $error("result item arrived with no item outstanding");
        mismatches++;
      end else begin
        oldest_head = expected_heads.pop_front();
        check_field("status", 32'(oldest_head.status), 32'(result.status));
        check_field("head_valid", 32'(oldest_head.head_valid), 32'(result.head_valid));
        check_field("head_id", 32'(oldest_head.head_id), 32'(result.head_id));
        check_field("head_seconds", oldest_head.head_seconds, result.head_seconds);
        check_field("head_micros", 32'(oldest_head.head_micros), 32'(result.head_micros));
        check_field("queued_count", 32'(oldest_head.queued_count),
                    32'(result.queued_count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("sorted_event_queue verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int i;
    // Directed: empty queue, extreme ids and times, ties, duplicate, full.
    add_item(OP_REMOVE, 8'd5, 32'd0, 20'd0, 0, 1'b0);
    add_item(OP_INSERT, 8'h00, 32'd0, 20'd0, 0, 1'b0);
    add_item(OP_INSERT, 8'hFF, 32'hFFFF_FFFF, 20'hFFFFF, 0, 1'b0);
    add_item(OP_INSERT, 8'h10, 32'hFFFF_FFFF, 20'd0, 0, 1'b0);
    add_item(OP_INSERT, 8'h11, 32'hFFFF_FFFF, 20'd0, 0, 1'b0);
    add_item(OP_INSERT, 8'h00, 32'd0, 20'd0, 0, 1'b0);
    add_item(OP_REMOVE, 8'h00, 32'd0, 20'd0, 0, 1'b0);
    add_item(OP_REMOVE, 8'h11, 32'd0, 20'd0, 0, 1'b0);
    for (i = 0; i < 14; i++) begin
      add_item(OP_INSERT, 8'(8'h20 + i), 32'd100, 20'(i % 3), 0, 1'b0);
    end
    add_item(OP_INSERT, 8'h55, 32'd1, 20'd0, 0, 1'b0);
    add_item(OP_INSERT, 8'h10, 32'd1, 20'd0, 0, 1'b0);
    add_item(OP_REMOVE, 8'hFF, 32'hAAAA_5555, 20'h5A5A5, 0, 1'b0);

    add_random_phase(0);
    add_random_phase(78);
    add_random_phase(0);
    add_random_phase(32);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (pending_cmds.size() != 0 || in_flight != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_heads.size() == 0) begin
      $display("sorted_event_queue verification clean");
    end else begin
      $display("sorted_event_queue verification failed");
    end
    $finish;
  end

endmodule
